FILE: rtl/cbpt_pkg.sv
// Package for the capnogram breath phase tracker.
// Holds widths, phase and register codes, the config/result structs and helper functions.
// No dependencies.
package cbpt_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int COUNT_WIDTH  = 16;

	localparam int CFG_WIDTH  = 17;
	localparam int LIM_WIDTH  = 16;
	localparam int IDX_WIDTH  = 3;
	localparam int PH_WIDTH   = 3;
	localparam int ET_WIDTH   = 10;
	localparam int IN_BYTES_W = 16;
	localparam int OUT_DATA_W = 16;

	// signed compare width for samples, differences and thresholds
	localparam int EXT_WIDTH = ((SAMPLE_WIDTH > CFG_WIDTH) ? SAMPLE_WIDTH : CFG_WIDTH) + 2;
	// unsigned compare width for counters against limits
	localparam int CMP_WIDTH = (COUNT_WIDTH > LIM_WIDTH) ? COUNT_WIDTH : LIM_WIDTH;

	// etCO2 divide by 100 as multiply by a rounded-up reciprocal, exact over the sample range
	localparam int ETCO2_DIV = 100;
	localparam int DIV_SHIFT = SAMPLE_WIDTH + 7;
	localparam int MULT_W    = SAMPLE_WIDTH + 1;
	localparam int PROD_W    = SAMPLE_WIDTH + MULT_W;
	localparam logic [63:0] DIV_MULT64 =
		((64'd1 << DIV_SHIFT) + 64'(ETCO2_DIV - 1)) / 64'(ETCO2_DIV);
	localparam logic [MULT_W-1:0] DIV_MULT = DIV_MULT64[MULT_W-1:0];

	// phase codes
	localparam logic [PH_WIDTH-1:0] PH_WAIT = 3'd0;
	localparam logic [PH_WIDTH-1:0] PH_BASE = 3'd1;
	localparam logic [PH_WIDTH-1:0] PH_UP   = 3'd2;
	localparam logic [PH_WIDTH-1:0] PH_PLAT = 3'd3;
	localparam logic [PH_WIDTH-1:0] PH_INSP = 3'd4;

	// register indexes
	localparam logic [IDX_WIDTH-1:0] REG_CO2_LOW_LEVEL    = 3'd0;
	localparam logic [IDX_WIDTH-1:0] REG_BASELINE_RUN_MIN = 3'd1;
	localparam logic [IDX_WIDTH-1:0] REG_UPSTROKE_RUN_MIN = 3'd2;
	localparam logic [IDX_WIDTH-1:0] REG_PLATEAU_MAX_RISE = 3'd3;
	localparam logic [IDX_WIDTH-1:0] REG_PLATEAU_RUN_MIN  = 3'd4;
	localparam logic [IDX_WIDTH-1:0] REG_INSP_MIN_FALL    = 3'd5;
	localparam logic [IDX_WIDTH-1:0] REG_INSP_RUN_MIN     = 3'd6;
	localparam logic [IDX_WIDTH-1:0] REG_APNEA_RUN_MAX    = 3'd7;

	typedef struct packed {
		logic [LIM_WIDTH-1:0]        co2_low_level;
		logic [LIM_WIDTH-1:0]        baseline_run_min;
		logic [LIM_WIDTH-1:0]        upstroke_run_min;
		logic signed [CFG_WIDTH-1:0] plateau_max_rise;
		logic [LIM_WIDTH-1:0]        plateau_run_min;
		logic signed [CFG_WIDTH-1:0] inspiration_min_fall;
		logic [LIM_WIDTH-1:0]        inspiration_run_min;
		logic [LIM_WIDTH-1:0]        apnea_run_max;
	} cfg_t;

	typedef struct packed {
		logic [PH_WIDTH-1:0] phase;
		logic                etco2_valid;
		logic [ET_WIDTH-1:0] etco2_value;
		logic                apnea_alarm;
	} res_t;

	function automatic logic signed [EXT_WIDTH-1:0] smp_ext(input logic [SAMPLE_WIDTH-1:0] v);
		return $signed(EXT_WIDTH'(v));
	endfunction

	function automatic logic signed [EXT_WIDTH-1:0] lim_ext(input logic [LIM_WIDTH-1:0] v);
		return $signed(EXT_WIDTH'(v));
	endfunction

	function automatic logic signed [EXT_WIDTH-1:0] thr_ext(input logic signed [CFG_WIDTH-1:0] v);
		return EXT_WIDTH'(v);
	endfunction

	// saturating run counter: +1 while the condition holds, 0 otherwise
	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c,
			input logic cond);
		if (!cond)
			return '0;
		else if (&c)
			return c;
		else
			return c + COUNT_WIDTH'(1);
	endfunction

	function automatic logic cnt_gt(input logic [COUNT_WIDTH-1:0] c,
			input logic [LIM_WIDTH-1:0] lim);
		return CMP_WIDTH'(c) > CMP_WIDTH'(lim);
	endfunction

	function automatic logic [ET_WIDTH-1:0] div100(input logic [SAMPLE_WIDTH-1:0] v);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(v) * PROD_W'(DIV_MULT);
		return ET_WIDTH'(prod >> DIV_SHIFT);
	endfunction

endpackage

FILE: rtl/cbpt_cfg_regs.sv
// Configuration register file for the breath phase tracker.
// Write-only registers decoded from a plain write port; uses cbpt_pkg.
module cbpt_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [cbpt_pkg::IDX_WIDTH-1:0] index,
	input  logic [cbpt_pkg::CFG_WIDTH-1:0] wdata,
	output cbpt_pkg::cfg_t                 cfg
);
	import cbpt_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (we) begin
			unique case (index)
				REG_CO2_LOW_LEVEL:    cfg_q.co2_low_level        <= wdata[LIM_WIDTH-1:0];
				REG_BASELINE_RUN_MIN: cfg_q.baseline_run_min     <= wdata[LIM_WIDTH-1:0];
				REG_UPSTROKE_RUN_MIN: cfg_q.upstroke_run_min     <= wdata[LIM_WIDTH-1:0];
				REG_PLATEAU_MAX_RISE: cfg_q.plateau_max_rise     <= $signed(wdata);
				REG_PLATEAU_RUN_MIN:  cfg_q.plateau_run_min      <= wdata[LIM_WIDTH-1:0];
				REG_INSP_MIN_FALL:    cfg_q.inspiration_min_fall <= $signed(wdata);
				REG_INSP_RUN_MIN:     cfg_q.inspiration_run_min  <= wdata[LIM_WIDTH-1:0];
				REG_APNEA_RUN_MAX:    cfg_q.apnea_run_max        <= wdata[LIM_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/cbpt_phase_core.sv
// Phase tracking core: run counters, phase registers, plateau peak and etCO2 scaling.
// Updates its state once per enabled sample; uses cbpt_pkg.
module cbpt_phase_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [cbpt_pkg::SAMPLE_WIDTH-1:0] sample,
	input  cbpt_pkg::cfg_t                    cfg,
	output cbpt_pkg::res_t                    res
);
	import cbpt_pkg::*;

	logic [PH_WIDTH-1:0]     cur_q, pend_q, pend_n, ph;
	logic [SAMPLE_WIDTH-1:0] prev_q, peak_q, peak_n;
	logic [COUNT_WIDTH-1:0]  low_q, rise_q, flat_q, fall_q, blen_q;
	logic [COUNT_WIDTH-1:0]  low_n, rise_n, flat_n, fall_n, blen_n;
	logic signed [EXT_WIDTH-1:0] s_x, p_x, rise_d, fall_d;

	assign ph     = pend_q;
	assign s_x    = smp_ext(sample);
	assign p_x    = smp_ext(prev_q);
	assign rise_d = s_x - p_x;
	assign fall_d = p_x - s_x;

	always_comb begin
		pend_n = pend_q;
		peak_n = peak_q;
		low_n  = low_q;
		rise_n = rise_q;
		flat_n = flat_q;
		fall_n = fall_q;
		blen_n = blen_q;
		unique case (ph)
			PH_WAIT: begin
				low_n = bump(low_q, s_x < lim_ext(cfg.co2_low_level));
				if (cnt_gt(low_n, cfg.baseline_run_min)) begin
					low_n  = '0;
					pend_n = PH_BASE;
				end
			end
			PH_BASE: begin
				rise_n = bump(rise_q, s_x > p_x);
				blen_n = bump(blen_q, 1'b1);
				if (cnt_gt(rise_n, cfg.upstroke_run_min)) begin
					blen_n = '0;
					pend_n = PH_UP;
				end
			end
			PH_UP: begin
				flat_n = bump(flat_q, rise_d < thr_ext(cfg.plateau_max_rise));
				if (cnt_gt(flat_n, cfg.plateau_run_min)) begin
					flat_n = '0;
					pend_n = PH_PLAT;
				end
			end
			PH_PLAT: begin
				if (cur_q != PH_PLAT || sample > peak_q)
					peak_n = sample;
				fall_n = bump(fall_q, fall_d > thr_ext(cfg.inspiration_min_fall));
				if (cnt_gt(fall_n, cfg.inspiration_run_min) ||
						s_x < lim_ext(cfg.co2_low_level)) begin
					fall_n = '0;
					pend_n = PH_INSP;
				end
			end
			PH_INSP: begin
				low_n = bump(low_q, s_x < thr_ext(cfg.inspiration_min_fall));
				if (cnt_gt(low_n, cfg.baseline_run_min)) begin
					low_n  = '0;
					pend_n = PH_BASE;
				end
			end
			default: begin
				pend_n = PH_UP;
			end
		endcase
	end

	always_comb begin
		res.phase       = ph;
		res.etco2_valid = (ph == PH_INSP) && (cur_q != PH_INSP);
		// peak is stable on inspiration entry, so it comes straight from its register
		res.etco2_value = res.etco2_valid ? div100(peak_q) : '0;
		res.apnea_alarm = (ph == PH_BASE) && cnt_gt(blen_n, cfg.apnea_run_max);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= PH_WAIT;
			pend_q <= PH_WAIT;
			prev_q <= '0;
			peak_q <= '0;
			low_q  <= '0;
			rise_q <= '0;
			flat_q <= '0;
			fall_q <= '0;
			blen_q <= '0;
		end else if (en) begin
			cur_q  <= ph;
			pend_q <= pend_n;
			prev_q <= sample;
			peak_q <= peak_n;
			low_q  <= low_n;
			rise_q <= rise_n;
			flat_q <= flat_n;
			fall_q <= fall_n;
			blen_q <= blen_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_peak_load: assert property (@(posedge clk) disable iff (!arst_n)
		en && pend_q == PH_PLAT && cur_q != PH_PLAT |=> peak_q == $past(sample))
		else $error("plateau peak not loaded on plateau entry");
	a_peak_hold: assert property (@(posedge clk) disable iff (!arst_n)
		en && pend_q != PH_PLAT |=> peak_q == $past(peak_q))
		else $error("plateau peak changed outside plateau");
	a_blen_clear: assert property (@(posedge clk) disable iff (!arst_n)
		en && pend_q == PH_BASE && pend_n == PH_UP |=> blen_q == '0)
		else $error("baseline length not cleared on upstroke entry");
`endif

endmodule

FILE: rtl/capnogram_breath_phase_tracker_unit.sv
// Top level of the capnogram breath phase tracker: input stage, core and output register.
// Depends on cbpt_pkg, cbpt_cfg_regs and cbpt_phase_core.
//
//  port group  dir  width  transaction content
//  s_*         in   16     co2_sample
//  m_*         out  16     phase, etco2_valid, etco2_value, apnea_alarm
//  cfg_*       in   3+17   register index and write data
//
// One sample per clock sustained while the output is not stalled by m_tready.
// The per-sample work is one pass of compares and counter updates plus the etCO2
// reciprocal multiply, between the input stage register and the output register.
// Reset clears phase, counters, peak, configuration and both valid flags to zero.
// A stalled output holds its data; s_tready falls only when both stages are full.
module capnogram_breath_phase_tracker_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cbpt_pkg::IN_BYTES_W-1:0] s_tdata,  // [15:0] co2_sample
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cbpt_pkg::OUT_DATA_W-1:0] m_tdata,  // [2:0] phase, [3] etco2_valid,
	                                                  // [13:4] etco2_value, [14] apnea_alarm
	input  logic                            cfg_we,
	input  logic [cbpt_pkg::IDX_WIDTH-1:0]  cfg_index,
	input  logic [cbpt_pkg::CFG_WIDTH-1:0]  cfg_wdata
);
	import cbpt_pkg::*;

	cfg_t cfg;
	res_t res;

	logic                    v_s1;
	logic [SAMPLE_WIDTH-1:0] sample_s1;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic                    adv, s_acc, en;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !v_s1 || adv;
	assign s_acc    = s_tvalid && s_tready;
	assign en       = v_s1 && adv;

	cbpt_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	cbpt_phase_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.sample (sample_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_acc)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;
			if (adv)
				out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc)
			sample_s1 <= SAMPLE_WIDTH'(s_tdata);
		if (en)
			out_data_q <= OUT_DATA_W'({res.apnea_alarm, res.etco2_value,
				res.etco2_valid, res.phase});
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	a_et_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2:0] == PH_INSP)
		else $error("etCO2 reported outside inspiration entry");
	a_apnea_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> m_tdata[2:0] == PH_BASE)
		else $error("apnea alarm outside baseline");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1)
		else $error("stage one item lost under stall");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> out_valid_q)
		else $error("processed item did not reach the output register");
`endif

endmodule
